[rtl/sip_pkg.sv]
// Shared types, constants and codes for the SipHash tag block.
`timescale 1ns / 1ps

package sip_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned MSG_DEPTH = 4;

   localparam int unsigned DEF_COMPRESS_ROUNDS = 2;
   localparam int unsigned DEF_FINAL_ROUNDS = 4;

   localparam logic [WORD_W-1:0] IV0 = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] IV1 = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] IV2 = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] IV3 = 64'h7465646279746573;
   localparam logic [WORD_W-1:0] FINAL_MARK = 64'h00000000000000ff;

   localparam logic [7:0] SHORT_LEN = 8'd20;
   localparam logic [7:0] LONG_LEN = 8'd32;

   // Blocks still queued behind the first one.
   localparam logic [2:0] SHORT_BLOCKS_LEFT = 3'd2;
   localparam logic [2:0] LONG_BLOCKS_LEFT = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH = 8'd1;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
   } sip_state_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_FINAL
   } st_type;

endpackage

[rtl/sip_round.sv]
// One SipRound over the four-word state, shared by every round of an item.
`timescale 1ns / 1ps

module sip_round (
   input  sip_pkg::sip_state_type in_state,
   output sip_pkg::sip_state_type out_state
);

   logic [sip_pkg::WORD_W-1:0] a1, b1, c1, d1;
   logic [sip_pkg::WORD_W-1:0] a2, b2, c2, d2;

   always_comb begin
      // First half: the two independent add-rotate-xor lanes.
      a1 = in_state.a + in_state.b;
      b1 = {in_state.b[50:0], in_state.b[63:51]} ^ a1;
      a1 = {a1[31:0], a1[63:32]};
      c1 = in_state.c + in_state.d;
      d1 = {in_state.d[47:0], in_state.d[63:48]} ^ c1;
      // Second half: the lanes cross over.
      a2 = a1 + d1;
      d2 = {d1[42:0], d1[63:43]} ^ a2;
      c2 = c1 + b1;
      b2 = {b1[46:0], b1[63:47]} ^ c2;
      out_state.a = a2;
      out_state.b = b2;
      out_state.c = {c2[31:0], c2[63:32]};
      out_state.d = d2;
   end

endmodule

[rtl/siphash_fixed_length_tag.sv]
// Top level of the keyed SipHash tag block over 20- or 32-byte messages.
`timescale 1ns / 1ps

// One SipRound unit is reused once a cycle under a small sequencer. After start
// is taken, busy stays high while the item runs COMPRESS_ROUNDS rounds per block
// and then FINAL_ROUNDS final rounds: a 20-byte item absorbs 3 blocks and a
// 32-byte item 5. The tag then appears on rsp_tag with rsp_valid high for
// exactly one cycle, the first cycle in which busy is low again, and there is no
// way to hold it off: the receiver must take it then.
// A new item may be started in that same cycle. Key registers are written
// through the csr port, which is always ready; write them only while busy is low.

module siphash_fixed_length_tag #(
   parameter int unsigned COMPRESS_ROUNDS = sip_pkg::DEF_COMPRESS_ROUNDS,
   parameter int unsigned FINAL_ROUNDS = sip_pkg::DEF_FINAL_ROUNDS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_long_mode,
   input  logic [sip_pkg::WORD_W-1:0]          req_word_a,
   input  logic [sip_pkg::WORD_W-1:0]          req_word_b,
   input  logic [sip_pkg::WORD_W-1:0]          req_word_c,
   input  logic [sip_pkg::WORD_W-1:0]          req_word_d,
   output logic                                rsp_valid,
   output logic [sip_pkg::WORD_W-1:0]          rsp_tag,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sip_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sip_pkg::WORD_W-1:0]          csr_wdata
);

   localparam int unsigned MAX_ROUNDS =
      (COMPRESS_ROUNDS > FINAL_ROUNDS) ? COMPRESS_ROUNDS : FINAL_ROUNDS;
   localparam int unsigned RCNT_W = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
   localparam logic [RCNT_W-1:0] COMP_LAST = RCNT_W'(COMPRESS_ROUNDS - 1);
   localparam logic [RCNT_W-1:0] FINAL_LAST = RCNT_W'(FINAL_ROUNDS - 1);

   sip_pkg::st_type state_ff, state_in;
   sip_pkg::sip_state_type v_ff, v_in, v_round;
   logic [sip_pkg::WORD_W-1:0] key_low_ff, key_low_in;
   logic [sip_pkg::WORD_W-1:0] key_high_ff, key_high_in;
   logic [sip_pkg::WORD_W-1:0] cur_ff, cur_in;
   logic [sip_pkg::WORD_W-1:0] msg_ff [sip_pkg::MSG_DEPTH];
   logic [sip_pkg::WORD_W-1:0] msg_in [sip_pkg::MSG_DEPTH];
   logic [2:0] blk_left_ff, blk_left_in;
   logic [RCNT_W-1:0] rcnt_ff, rcnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [sip_pkg::WORD_W-1:0] tag_ff, tag_in;
   logic [sip_pkg::WORD_W-1:0] short_last;
   logic accept;

   sip_round u_round (
      .in_state  (v_ff),
      .out_state (v_round)
   );

   assign busy = (state_ff != sip_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_tag = tag_ff;
   assign short_last = {sip_pkg::SHORT_LEN, 24'd0, req_word_c[31:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sip_pkg::ST_IDLE;
         key_low_ff <= '0;
         key_high_ff <= '0;
         rsp_valid_ff <= 1'b0;
         blk_left_ff <= '0;
         rcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         key_low_ff <= key_low_in;
         key_high_ff <= key_high_in;
         rsp_valid_ff <= rsp_valid_in;
         blk_left_ff <= blk_left_in;
         rcnt_ff <= rcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      cur_ff <= cur_in;
      msg_ff <= msg_in;
      tag_ff <= tag_in;
   end

   always_comb begin
      key_low_in = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sip_pkg::CSR_KEY_LOW: key_low_in = csr_wdata;
            sip_pkg::CSR_KEY_HIGH: key_high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      v_in = v_ff;
      cur_in = cur_ff;
      msg_in = msg_ff;
      blk_left_in = blk_left_ff;
      rcnt_in = rcnt_ff;
      rsp_valid_in = 1'b0;
      tag_in = tag_ff;

      unique case (state_ff)
         sip_pkg::ST_IDLE: begin
            if (accept) begin
               // Initial state with the first block already mixed into d.
               v_in.a = sip_pkg::IV0 ^ key_low_ff;
               v_in.b = sip_pkg::IV1 ^ key_high_ff;
               v_in.c = sip_pkg::IV2 ^ key_low_ff;
               v_in.d = sip_pkg::IV3 ^ key_high_ff ^ req_word_a;
               cur_in = req_word_a;
               msg_in[0] = req_word_b;
               if (req_long_mode) begin
                  msg_in[1] = req_word_c;
                  msg_in[2] = req_word_d;
                  msg_in[3] = {sip_pkg::LONG_LEN, 56'd0};
                  blk_left_in = sip_pkg::LONG_BLOCKS_LEFT;
               end else begin
                  msg_in[1] = short_last;
                  msg_in[2] = short_last;
                  msg_in[3] = short_last;
                  blk_left_in = sip_pkg::SHORT_BLOCKS_LEFT;
               end
               rcnt_in = '0;
               state_in = sip_pkg::ST_ABSORB;
            end
         end

         sip_pkg::ST_ABSORB: begin
            v_in = v_round;
            rcnt_in = rcnt_ff + RCNT_W'(1);
            if (rcnt_ff == COMP_LAST) begin
               // Close the current block and open the next one in the same cycle.
               v_in.a = v_round.a ^ cur_ff;
               rcnt_in = '0;
               if (blk_left_ff != 3'd0) begin
                  v_in.d = v_round.d ^ msg_ff[0];
                  cur_in = msg_ff[0];
                  for (int i = 0; i < sip_pkg::MSG_DEPTH - 1; i++) begin
                     msg_in[i] = msg_ff[i+1];
                  end
                  blk_left_in = blk_left_ff - 3'd1;
               end else begin
                  v_in.c = v_round.c ^ sip_pkg::FINAL_MARK;
                  state_in = sip_pkg::ST_FINAL;
               end
            end
         end

         sip_pkg::ST_FINAL: begin
            v_in = v_round;
            rcnt_in = rcnt_ff + RCNT_W'(1);
            if (rcnt_ff == FINAL_LAST) begin
               tag_in = v_round.a ^ v_round.b ^ v_round.c ^ v_round.d;
               rsp_valid_in = 1'b1;
               rcnt_in = '0;
               state_in = sip_pkg::ST_IDLE;
            end
         end

         default: state_in = sip_pkg::ST_IDLE;
      endcase
   end

endmodule
